@@ src/cube_root_deadline_scaler_assert.svh @@
// assertion macros for the deadline scaler
`ifndef CUBE_ROOT_DEADLINE_SCALER_ASSERT_SVH
`define CUBE_ROOT_DEADLINE_SCALER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define CRDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also active during reset
`define CRDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRDS_ASSERT(lbl, clk, rstn, prop, msg)
`define CRDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/crds_pkg.sv @@
package crds_pkg;

  // gamma(4/3) in q42
  localparam logic [63:0] GammaQ42 = 64'd3927365422841;
  localparam int FracBits = 42;
  localparam int RootBits = 21;

  // cube root unit sizing
  localparam int CbrtSteps = 53;
  localparam int CbrtXW    = 3 * CbrtSteps;
  localparam int CbrtAccW  = 112;
  localparam int CbrtCntW  = $clog2(CbrtSteps);

  // divider and multiplier sizing
  localparam int DivNumW  = 128;
  localparam int DivDenW  = 64;
  localparam int DivCntW  = $clog2(DivNumW);
  localparam int MulW     = 64;
  localparam int MulCntW  = $clog2(MulW);

  // register indexes
  localparam logic [1:0] RegBaseTarget = 2'd0;
  localparam logic [1:0] RegBlockTime  = 2'd1;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRootT = 7'b0000010,
    StMulG  = 7'b0000100,
    StDivS  = 7'b0001000,
    StDivV  = 7'b0010000,
    StRootV = 7'b0100000,
    StMulR  = 7'b1000000
  } state_e;

endpackage

@@ src/cube_root_deadline_scaler.sv @@
// cube root deadline scaler
// an item is a 64-bit quality; a request is taken at a rising edge with start
// high and busy low. the result (deadline_o, status_o) shows for one cycle
// with done_o high; the receiver cannot stall, so it must take it then.
// configuration: cfg_index_i 0 is the quality divisor, 1 is the target
// interval (low 32 bits kept), other indexes are ignored. cfg_ready_o is high
// while idle.
// a zero quality is answered straight from idle with deadline 0, status 0. a
// zero divisor or interval is answered straight from idle with deadline 0, status 1.
// otherwise the item runs through one cube root unit, one restoring divider
// and one shift-add multiplier in turn: root of the interval, gamma product,
// scale division, quality division, root of the normalized quality and final
// product; busy drops together with done_o, so a new request can be taken at
// the edge that ends the result cycle, and no new quality is taken while the
// previous one is still running.
// reset returns the divisor to 1, the interval to 120 and the block to idle.
module cube_root_deadline_scaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] quality_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [63:0] deadline_o,
  output logic        status_o
);

`include "cube_root_deadline_scaler_assert.svh"

  crds_pkg::state_e state_q, state_d;
  logic [63:0] bt_q, q_q, den_q, scale_q, deadline_q, deadline_d;
  logic [31:0] tt_q;
  logic        done_q, done_d, status_q, status_d;
  logic        cbrt_go_q, cbrt_go_d, div_go_q, div_go_d, mul_go_q, mul_go_d;
  logic        cbrt_done, div_done, mul_done;
  logic [crds_pkg::CbrtXW-1:0]      cbrt_x;
  logic [crds_pkg::CbrtSteps-1:0]   cbrt_root;
  logic [crds_pkg::DivNumW-1:0]     div_num, div_quot;
  logic [crds_pkg::DivDenW-1:0]     div_den;
  logic [crds_pkg::MulW-1:0]        mul_a, mul_b;
  logic [2*crds_pkg::MulW-1:0]      mul_p, rnd_w;
  logic                             take;

  assign take        = start && !busy;
  assign busy        = (state_q != crds_pkg::StIdle);
  assign cfg_ready_o = !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q <= 64'd1;
      tt_q <= 32'd120;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == crds_pkg::RegBaseTarget) begin
        bt_q <= cfg_data_i;
      end else if (cfg_index_i == crds_pkg::RegBlockTime) begin
        tt_q <= cfg_data_i[31:0];
      end
    end
  end

  // operand selection for the shared units
  assign cbrt_x = (state_q == crds_pkg::StRootT)
                ? {1'b0, tt_q, 126'b0}
                : {31'b0, div_quot};
  assign div_num = (state_q == crds_pkg::StDivS)
                 ? (crds_pkg::DivNumW'({tt_q, 84'b0}) + crds_pkg::DivNumW'(den_q[63:1]))
                 : {1'b0, q_q, 63'b0};
  assign div_den = (state_q == crds_pkg::StDivS) ? den_q : bt_q;
  assign mul_a   = (state_q == crds_pkg::StMulG) ? 64'(cbrt_root) : scale_q;
  assign mul_b   = (state_q == crds_pkg::StMulG) ? crds_pkg::GammaQ42 : 64'(cbrt_root);

  // rounding of the final product
  assign rnd_w = mul_p + (128'd1 << (crds_pkg::RootBits + crds_pkg::FracBits - 1));

  // sequencer
  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    status_d   = status_q;
    deadline_d = deadline_q;
    cbrt_go_d  = 1'b0;
    div_go_d   = 1'b0;
    mul_go_d   = 1'b0;
    unique case (state_q)
      crds_pkg::StIdle: begin
        if (take) begin
          if (quality_i == 64'd0) begin
            done_d     = 1'b1;
            status_d   = 1'b0;
            deadline_d = '0;
          end else if (bt_q == 64'd0 || tt_q == 32'd0) begin
            done_d     = 1'b1;
            status_d   = 1'b1;
            deadline_d = '0;
          end else begin
            state_d   = crds_pkg::StRootT;
            cbrt_go_d = 1'b1;
          end
        end
      end
      crds_pkg::StRootT: begin
        if (cbrt_done) begin
          state_d  = crds_pkg::StMulG;
          mul_go_d = 1'b1;
        end
      end
      crds_pkg::StMulG: begin
        if (mul_done) begin
          state_d  = crds_pkg::StDivS;
          div_go_d = 1'b1;
        end
      end
      crds_pkg::StDivS: begin
        if (div_done) begin
          state_d  = crds_pkg::StDivV;
          div_go_d = 1'b1;
        end
      end
      crds_pkg::StDivV: begin
        if (div_done) begin
          state_d   = crds_pkg::StRootV;
          cbrt_go_d = 1'b1;
        end
      end
      crds_pkg::StRootV: begin
        if (cbrt_done) begin
          state_d  = crds_pkg::StMulR;
          mul_go_d = 1'b1;
        end
      end
      crds_pkg::StMulR: begin
        if (mul_done) begin
          state_d    = crds_pkg::StIdle;
          done_d     = 1'b1;
          status_d   = 1'b0;
          deadline_d = rnd_w[126:63];
        end
      end
      default: begin
        state_d = crds_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crds_pkg::StIdle;
      done_q    <= 1'b0;
      cbrt_go_q <= 1'b0;
      div_go_q  <= 1'b0;
      mul_go_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      cbrt_go_q <= cbrt_go_d;
      div_go_q  <= div_go_d;
      mul_go_q  <= mul_go_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    deadline_q <= deadline_d;
    if (take) begin
      q_q <= quality_i;
    end
    if (state_q == crds_pkg::StMulG && mul_done) begin
      den_q <= mul_p[105:42];
    end
    if (state_q == crds_pkg::StDivS && div_done) begin
      scale_q <= div_quot[63:0];
    end
  end

  crds_cbrt u_cbrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cbrt_go_q),
    .x_i    (cbrt_x),
    .done_o (cbrt_done),
    .root_o (cbrt_root)
  );

  crds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  crds_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  assign done_o     = done_q;
  assign deadline_o = deadline_q;
  assign status_o   = status_q;

  `CRDS_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "result while busy")
  `CRDS_ASSERT(a_zero_q, clk_i, rst_ni, (take && quality_i == 64'd0) |=> (done_o && deadline_o == 64'd0 && !status_o), "zero quality not answered")
  `CRDS_ASSERT(a_err_zero, clk_i, rst_ni, (done_o && status_o) |-> (deadline_o == 64'd0), "error with nonzero deadline")
  `CRDS_ASSERT(a_go_busy, clk_i, rst_ni, (cbrt_go_q || div_go_q || mul_go_q) |-> (busy && !done_o), "unit started while idle")
  `CRDS_ASSERT_ALWAYS(a_one_go, clk_i, $onehot0({cbrt_go_q, div_go_q, mul_go_q}), "two units started")

endmodule

@@ src/crds_cbrt.sv @@
module crds_cbrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic [crds_pkg::CbrtXW-1:0]       x_i,
  output logic                              done_o,
  output logic [crds_pkg::CbrtSteps-1:0]    root_o
);

  localparam int AW = crds_pkg::CbrtAccW;
  localparam int XW = crds_pkg::CbrtXW;

  logic [XW-1:0]                     x_q;
  logic [AW-1:0]                     rem_q, term_q, s_q;
  logic [crds_pkg::CbrtSteps-1:0]    y_q;
  logic [crds_pkg::CbrtCntW-1:0]     cnt_q;
  logic                              run_q, phase_q, done_q;
  logic [AW-1:0]                     y_w, term_d;

  assign y_w = AW'(y_q);
  // 12*y^2 + 6*y + 1 is the cost of setting the next root bit
  assign term_d = (AW'({s_q, 3'b0}) + AW'({s_q, 2'b0}))
                + (AW'({y_w, 2'b0}) + AW'({y_w, 1'b0})) + AW'(1);

  // digit-by-digit root, three operand bits per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q   <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (run_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (cnt_q == crds_pkg::CbrtCntW'(crds_pkg::CbrtSteps - 1)) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      x_q   <= x_i;
      rem_q <= '0;
      s_q   <= '0;
      y_q   <= '0;
    end else if (run_q) begin
      if (!phase_q) begin
        rem_q  <= {rem_q[AW-4:0], x_q[XW-1 -: 3]};
        x_q    <= {x_q[XW-4:0], 3'b000};
        term_q <= term_d;
      end else if (rem_q >= term_q) begin
        rem_q <= rem_q - term_q;
        s_q   <= {s_q[AW-3:0], 2'b00} + {y_w[AW-3:0], 2'b00} + AW'(1);
        y_q   <= {y_q[crds_pkg::CbrtSteps-2:0], 1'b1};
      end else begin
        s_q <= {s_q[AW-3:0], 2'b00};
        y_q <= {y_q[crds_pkg::CbrtSteps-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = y_q;

endmodule

@@ src/crds_div.sv @@
module crds_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  logic [crds_pkg::DivNumW-1:0]     num_i,
  input  logic [crds_pkg::DivDenW-1:0]     den_i,
  output logic                             done_o,
  output logic [crds_pkg::DivNumW-1:0]     quot_o
);

  localparam int NW = crds_pkg::DivNumW;
  localparam int DW = crds_pkg::DivDenW;

  logic [NW-1:0]               num_q;
  logic [DW-1:0]               den_q, rem_q;
  logic [crds_pkg::DivCntW-1:0] cnt_q;
  logic                        run_q, done_q;
  logic [DW:0]                 sh_w, diff_w;
  logic                        ge_w;

  // one restoring step per cycle
  assign sh_w   = {rem_q, num_q[NW-1]};
  assign ge_w   = sh_w >= {1'b0, den_q};
  assign diff_w = sh_w - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == crds_pkg::DivCntW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // quotient bits shift in behind the numerator
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= ge_w ? diff_w[DW-1:0] : sh_w[DW-1:0];
      num_q <= {num_q[NW-2:0], ge_w};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ src/crds_mul.sv @@
module crds_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [crds_pkg::MulW-1:0]     a_i,
  input  logic [crds_pkg::MulW-1:0]     b_i,
  output logic                          done_o,
  output logic [2*crds_pkg::MulW-1:0]   prod_o
);

  localparam int W = crds_pkg::MulW;

  logic [2*W-1:0]               a_q, p_q;
  logic [W-1:0]                 b_q;
  logic [crds_pkg::MulCntW-1:0] cnt_q;
  logic                         run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == crds_pkg::MulCntW'(W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q <= {{W{1'b0}}, a_i};
      b_q <= b_i;
      p_q <= '0;
    end else if (run_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= {a_q[2*W-2:0], 1'b0};
      b_q <= {1'b0, b_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ test/cube_root_deadline_scaler_tb.sv @@
module cube_root_deadline_scaler_tb;

  localparam int          ClkPeriod   = 10;
  localparam int          NumPhases   = 13;
  localparam int          PhaseItems  = 100;
  localparam int          CycleLimit  = 3_000_000;
  localparam int          DrainCycles = 700;
  localparam logic [1:0]  RegSpare2   = 2'd2;
  localparam logic [1:0]  RegSpare3   = 2'd3;
  localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    logic [63:0] deadline;
    logic        status;
  } deadline_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [63:0] data;
    logic        known;
    deadline_t   result;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] quality_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        done_o;
  logic [63:0] deadline_o;
  logic        status_o;

  // register copies kept by the predictor
  logic [63:0] model_divisor;
  logic [31:0] model_interval;

  deadline_t   pending_deadlines[$];
  int          num_errors;
  int          cycle_count;
  bit          no_gaps;

  dir_row_t dir_rows [22] = '{
    '{RowItem, crds_pkg::RegBaseTarget, 64'd0,   1'b1, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd1,   1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'h8000_0000_0000_0000, 1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  crds_pkg::RegBaseTarget, 64'd0,   1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd5,   1'b1, '{64'd0, 1'b1}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd0,   1'b1, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, AllOnes, 1'b1, '{64'd0, 1'b1}},
    '{RowCfg,  crds_pkg::RegBaseTarget, AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd1,   1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  crds_pkg::RegBlockTime,  64'd0,   1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd7,   1'b1, '{64'd0, 1'b1}},
    '{RowCfg,  crds_pkg::RegBaseTarget, 64'd1,   1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  crds_pkg::RegBlockTime,  AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, 64'd1,   1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  RegSpare2,               64'h0,   1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  RegSpare3,               AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  crds_pkg::RegBlockTime,  64'd1,   1'b0, '{64'd0, 1'b0}},
    '{RowItem, crds_pkg::RegBaseTarget, AllOnes, 1'b0, '{64'd0, 1'b0}},
    '{RowCfg,  crds_pkg::RegBlockTime,  64'hABCD_0000_0000_0078, 1'b0, '{64'd0, 1'b0}}
  };

  cube_root_deadline_scaler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .quality_i  (quality_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .deadline_o (deadline_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // floor cube root of an operand below 2^192
  function automatic logic [63:0] floor_cbrt(logic [255:0] x);
    logic [63:0]  root;
    logic [63:0]  trial;
    logic [255:0] wide;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      wide  = {192'd0, trial};
      if (wide * wide * wide <= x) root = trial;
    end
    return root;
  endfunction

  // expected deadline and status for one quality under the current registers
  function automatic deadline_t predict_deadline(logic [63:0] quality);
    deadline_t    res;
    logic [255:0] t, tc, den, scale, v, prod;
    res = '0;
    if (quality == 64'd0) return res;
    if (model_divisor == 64'd0 || model_interval == 32'd0) begin
      res.status = 1'b1;
      return res;
    end
    t     = {224'd0, model_interval};
    tc    = {192'd0, floor_cbrt(t << (3 * crds_pkg::FracBits))};
    den   = (tc * {192'd0, crds_pkg::GammaQ42}) >> crds_pkg::FracBits;
    scale = ((t << (2 * crds_pkg::FracBits)) + (den >> 1)) / den;
    v     = ({192'd0, quality} << (3 * crds_pkg::RootBits)) / {192'd0, model_divisor};
    prod  = scale * {192'd0, floor_cbrt(v)}
          + (256'd1 << (crds_pkg::RootBits + crds_pkg::FracBits - 1));
    res.deadline = 64'(prod >> (crds_pkg::RootBits + crds_pkg::FracBits));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    num_errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one quality request, then queue its expected result
  task automatic send_quality(logic [63:0] quality, logic known, deadline_t typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    quality_i <= quality;
    do @(posedge clk_i); while (busy);
    pending_deadlines.push_back(known ? typed : predict_deadline(quality));
  endtask

  // let the block drain before touching a register
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_deadlines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write; the channel then stays quiet before the task returns
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      crds_pkg::RegBaseTarget: model_divisor  = data;
      crds_pkg::RegBlockTime:  model_interval = data[31:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_quality();
    logic [63:0] q;
    int r;
    q = {$urandom(), $urandom()};
    r = $urandom_range(0, 99);
    if (r < 3) return 64'd0;
    if (r < 6) return AllOnes;
    if (r < 40) return q >> $urandom_range(0, 63);
    return q;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    deadline_t want;
    if (rst_ni && done_o) begin
      if (pending_deadlines.size() == 0) begin
        report_mismatch("unexpected result", deadline_o, 64'd0);
      end else begin
        want = pending_deadlines.pop_front();
        if (deadline_o !== want.deadline) report_mismatch("deadline", deadline_o, want.deadline);
        if (status_o !== want.status)
          report_mismatch("status", {63'd0, status_o}, {63'd0, want.status});
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    logic [63:0] bt;
    logic [63:0] blk;
    num_errors     = 0;
    cycle_count    = 0;
    no_gaps        = 1'b0;
    model_divisor  = 64'd1;
    model_interval = 32'd120;
    rst_ni      = 1'b0;
    start       = 1'b0;
    quality_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = crds_pkg::RegBaseTarget;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_quality(dir_rows[i].data, dir_rows[i].known, dir_rows[i].result);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      r  = $urandom_range(0, 9);
      bt = (r == 0) ? 64'd0 : (r == 1) ? 64'd1 : (r == 2) ? AllOnes :
           ({$urandom(), $urandom()} >> $urandom_range(0, 63));
      r  = $urandom_range(0, 9);
      blk = (r == 0) ? 64'd0 : (r == 1) ? 64'd1 : (r == 2) ? 64'hFFFF_FFFF :
            {$urandom(), $urandom()} >> $urandom_range(0, 63);
      if (p == 0) begin
        bt  = AllOnes;
        blk = 64'hFFFF_FFFF;
      end else if (p == 1) begin
        bt  = 64'd1;
        blk = 64'd1;
      end
      write_reg(crds_pkg::RegBaseTarget, bt);
      write_reg(crds_pkg::RegBlockTime, blk);
      if ($urandom_range(0, 3) == 0)
        write_reg(RegSpare2 | 2'($urandom_range(0, 1)), {$urandom(), $urandom()});
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) send_quality(rand_quality(), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_deadlines.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (num_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/crds_pkg.sv
src/crds_cbrt.sv
src/crds_div.sv
src/crds_mul.sv
src/cube_root_deadline_scaler.sv
test/cube_root_deadline_scaler_tb.sv
